// ===== sv/ert_pkg.sv =====
// Package for the event retry table: shared widths, codes, entry layout
// and controller/datapath interface structs. No dependencies.
package ert_pkg;

  localparam int TABLE_SLOTS_DEF = 16;

  localparam int KEY_W   = 64;
  localparam int KIND_W  = 2;
  localparam int COUNT_W = 8;
  localparam int TIME_W  = 32;
  localparam int SLOT_W  = 4;
  localparam int RES_W   = 3;

  localparam logic [KIND_W-1:0] KIND_CHARGE  = 2'd0;
  localparam logic [KIND_W-1:0] KIND_NETWORK = 2'd1;

  typedef enum logic [1:0] {
    CMD_ADD  = 2'd0,
    CMD_ACK  = 2'd1,
    CMD_TICK = 2'd2
  } cmd_t;

  typedef enum logic [1:0] {
    PH_READY = 2'd0,
    PH_WAIT  = 2'd1,
    PH_DROP  = 2'd2
  } phase_t;

  typedef enum logic [RES_W-1:0] {
    RK_ADDED     = 3'd0,
    RK_FULL      = 3'd1,
    RK_REMOVED   = 3'd2,
    RK_NO_MATCH  = 3'd3,
    RK_SEND      = 3'd4,
    RK_TICK_DONE = 3'd5
  } res_kind_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_ADD,
    ST_ACK,
    ST_TICK,
    ST_TDONE
  } state_t;

  typedef struct packed {
    logic [KEY_W-1:0]   key;
    logic [KIND_W-1:0]  kind;
    logic [COUNT_W-1:0] target;
    logic [COUNT_W-1:0] sent;
    logic [TIME_W-1:0]  wait_ms;
    logic [TIME_W-1:0]  stamp;
  } entry_t;

  localparam int ENTRY_W = $bits(entry_t);

  typedef struct packed {
    logic      load;
    logic      add_wr;
    logic      ack_clr;
    logic      tick_upd;
    logic      emit;
    res_kind_t res_kind;
    logic      res_slot;
    logic      res_send;
    logic      res_last;
  } ctrl_t;

  typedef struct packed {
    logic ev_free;
    logic key_match;
    logic tick_send;
  } stat_t;

endpackage

// ===== sv/ert_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module ert_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== sv/ert_datapath.sv =====
// Datapath of the event retry table: valid and phase flops, entry RAM,
// captured command beat, slot evaluation and result registers.
// Depends on ert_pkg and ert_ram.
module ert_datapath
  import ert_pkg::*;
#(
  parameter int TABLE_SLOTS = TABLE_SLOTS_DEF
) (
  input  logic                           clk,
  input  logic                           rst,
  input  ctrl_t                          ctrl,
  input  logic [$clog2(TABLE_SLOTS)-1:0] rd_addr,
  input  logic [$clog2(TABLE_SLOTS)-1:0] ev_idx,
  output stat_t                          stat,
  input  logic [KEY_W-1:0]               event_key,
  input  logic [KIND_W-1:0]              event_kind,
  input  logic [COUNT_W-1:0]             retry_limit,
  input  logic [TIME_W-1:0]              retry_interval,
  input  logic [TIME_W-1:0]              now_ms,
  output logic                           strobe,
  output logic [RES_W-1:0]               result_kind,
  output logic [SLOT_W-1:0]              slot,
  output logic [KEY_W-1:0]               send_key,
  output logic                           send_kind,
  output logic                           last
);

  logic [TABLE_SLOTS-1:0] valid;
  phase_t                 phase [TABLE_SLOTS];

  logic [KEY_W-1:0]   cmd_key;
  logic [KIND_W-1:0]  cmd_kind;
  logic [COUNT_W-1:0] cmd_limit;
  logic [TIME_W-1:0]  cmd_interval;
  logic [TIME_W-1:0]  cmd_now;

  entry_t             rd;
  entry_t             upd;
  entry_t             fresh;
  logic               ram_we;
  entry_t             ram_wdata;
  logic [COUNT_W-1:0] sent_next;
  logic [TIME_W-1:0]  elapsed;
  logic               ev_valid;
  phase_t             ev_phase;
  logic               sendable;

  ert_ram #(
    .WIDTH(ENTRY_W),
    .DEPTH(TABLE_SLOTS)
  ) u_ram (
    .clk  (clk),
    .we   (ram_we),
    .waddr(ev_idx),
    .wdata(ram_wdata),
    .raddr(rd_addr),
    .rdata(rd)
  );

  always_ff @(posedge clk) begin
    if (ctrl.load) begin
      cmd_key      <= event_key;
      cmd_kind     <= event_kind;
      cmd_limit    <= retry_limit;
      cmd_interval <= retry_interval;
      cmd_now      <= now_ms;
    end
  end

  always_comb begin
    ev_valid  = valid[ev_idx];
    ev_phase  = phase[ev_idx];
    sendable  = (rd.kind == KIND_CHARGE) || (rd.kind == KIND_NETWORK);
    sent_next = (rd.sent < {COUNT_W{1'b1}}) ? rd.sent + 1'b1 : rd.sent;
    elapsed   = cmd_now - rd.stamp;

    upd      = rd;
    upd.sent = sent_next;
    if (sent_next < rd.target) begin
      upd.stamp = cmd_now;
    end

    fresh.key     = cmd_key;
    fresh.kind    = cmd_kind;
    fresh.target  = cmd_limit;
    fresh.sent    = '0;
    fresh.wait_ms = cmd_interval;
    fresh.stamp   = cmd_now;

    ram_we    = ctrl.add_wr || (ctrl.tick_upd && ev_valid && ev_phase == PH_READY);
    ram_wdata = ctrl.add_wr ? fresh : upd;

    stat.ev_free   = !ev_valid;
    stat.key_match = ev_valid && (rd.key == cmd_key);
    stat.tick_send = ev_valid && (ev_phase == PH_READY) && sendable;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= '0;
      for (int i = 0; i < TABLE_SLOTS; i++) begin
        phase[i] <= PH_READY;
      end
    end else if (ctrl.add_wr) begin
      valid[ev_idx] <= 1'b1;
      phase[ev_idx] <= PH_READY;
    end else if (ctrl.ack_clr) begin
      valid[ev_idx] <= 1'b0;
      phase[ev_idx] <= PH_READY;
    end else if (ctrl.tick_upd && ev_valid) begin
      unique case (ev_phase)
        PH_READY: begin
          phase[ev_idx] <= (sent_next < rd.target) ? PH_WAIT : PH_DROP;
        end
        PH_WAIT: begin
          if (elapsed >= rd.wait_ms) begin
            phase[ev_idx] <= PH_READY;
          end
        end
        PH_DROP: begin
          valid[ev_idx] <= 1'b0;
          phase[ev_idx] <= PH_READY;
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      strobe <= 1'b0;
    end else begin
      strobe <= ctrl.emit;
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.emit) begin
      result_kind <= ctrl.res_kind;
      slot        <= ctrl.res_slot ? SLOT_W'(ev_idx) : '0;
      send_key    <= ctrl.res_send ? rd.key : '0;
      send_kind   <= ctrl.res_send ? rd.kind[0] : 1'b0;
      last        <= ctrl.res_last;
    end
  end

endmodule

// ===== sv/ert_ctrl.sv =====
// Controller of the event retry table: walks slots for add, ack and tick
// commands and issues datapath commands. Depends on ert_pkg.
module ert_ctrl
  import ert_pkg::*;
#(
  parameter int TABLE_SLOTS = TABLE_SLOTS_DEF
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           start,
  input  logic [1:0]                     cmd,
  output logic                           busy,
  input  stat_t                          stat,
  output ctrl_t                          ctrl,
  output logic [$clog2(TABLE_SLOTS)-1:0] rd_addr,
  output logic [$clog2(TABLE_SLOTS)-1:0] ev_idx
);

  localparam int IDX_W = $clog2(TABLE_SLOTS);
  localparam logic [IDX_W-1:0] LastIdx = IDX_W'(TABLE_SLOTS - 1);

  state_t           state;
  state_t           state_next;
  logic [IDX_W-1:0] idx;
  logic [IDX_W-1:0] idx_next;
  logic             at_last;

  assign at_last = (idx == LastIdx);
  assign ev_idx  = idx;
  assign busy    = (state != ST_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      idx   <= '0;
    end else begin
      state <= state_next;
      idx   <= idx_next;
    end
  end

  always_comb begin
    state_next = state;
    idx_next   = idx;
    unique case (state)
      ST_IDLE: begin
        idx_next = '0;
        if (start) begin
          unique case (cmd)
            CMD_ADD:  state_next = ST_ADD;
            CMD_ACK:  state_next = ST_ACK;
            CMD_TICK: state_next = ST_TICK;
            default:  state_next = ST_IDLE;
          endcase
        end
      end
      ST_ADD: begin
        if (stat.ev_free || at_last) begin
          state_next = ST_IDLE;
        end else begin
          idx_next = idx + 1'b1;
        end
      end
      ST_ACK: begin
        if (stat.key_match || at_last) begin
          state_next = ST_IDLE;
        end else begin
          idx_next = idx + 1'b1;
        end
      end
      ST_TICK: begin
        if (at_last) begin
          state_next = ST_TDONE;
        end else begin
          idx_next = idx + 1'b1;
        end
      end
      ST_TDONE: begin
        state_next = ST_IDLE;
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    ctrl          = '0;
    ctrl.res_kind = RK_ADDED;
    rd_addr       = at_last ? '0 : idx + 1'b1;
    unique case (state)
      ST_IDLE: begin
        rd_addr   = '0;
        ctrl.load = start;
      end
      ST_ADD: begin
        if (stat.ev_free) begin
          ctrl.add_wr   = 1'b1;
          ctrl.emit     = 1'b1;
          ctrl.res_kind = RK_ADDED;
          ctrl.res_slot = 1'b1;
          ctrl.res_last = 1'b1;
        end else if (at_last) begin
          ctrl.emit     = 1'b1;
          ctrl.res_kind = RK_FULL;
          ctrl.res_last = 1'b1;
        end
      end
      ST_ACK: begin
        if (stat.key_match) begin
          ctrl.ack_clr  = 1'b1;
          ctrl.emit     = 1'b1;
          ctrl.res_kind = RK_REMOVED;
          ctrl.res_slot = 1'b1;
          ctrl.res_last = 1'b1;
        end else if (at_last) begin
          ctrl.emit     = 1'b1;
          ctrl.res_kind = RK_NO_MATCH;
          ctrl.res_last = 1'b1;
        end
      end
      ST_TICK: begin
        ctrl.tick_upd = 1'b1;
        if (stat.tick_send) begin
          ctrl.emit     = 1'b1;
          ctrl.res_kind = RK_SEND;
          ctrl.res_slot = 1'b1;
          ctrl.res_send = 1'b1;
        end
      end
      ST_TDONE: begin
        ctrl.emit     = 1'b1;
        ctrl.res_kind = RK_TICK_DONE;
        ctrl.res_last = 1'b1;
      end
      default: begin
      end
    endcase
  end

endmodule

// ===== sv/event_retry_table.sv =====
// Top level of the event retry table: controller plus datapath.
// Depends on ert_pkg, ert_ctrl, ert_datapath.
//
//   channel  handshake          payload
//   input    start & !busy      cmd, event_key, event_kind, retry_limit,
//                               retry_interval, now_ms
//   result   strobe (1 cycle)   result_kind, slot, send_key, send_kind, last
//
// An add or ack walks the slots one per cycle from slot 0 and stops at the
// first hit. A tick walks every slot, one per cycle through the entry RAM
// read port, then emits tick done. Command 3 raises no busy and no result.
// Reset is synchronous and clears valid and phase flops; no clearing pass.
// Results leave on a one-cycle strobe; the receiver cannot stall.
module event_retry_table
  import ert_pkg::*;
#(
  parameter int TABLE_SLOTS = TABLE_SLOTS_DEF
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                start,
  output logic                busy,
  input  logic [1:0]          cmd,
  input  logic [KEY_W-1:0]    event_key,
  input  logic [KIND_W-1:0]   event_kind,
  input  logic [COUNT_W-1:0]  retry_limit,
  input  logic [TIME_W-1:0]   retry_interval,
  input  logic [TIME_W-1:0]   now_ms,
  output logic                strobe,
  output logic [RES_W-1:0]    result_kind,
  output logic [SLOT_W-1:0]   slot,
  output logic [KEY_W-1:0]    send_key,
  output logic                send_kind,
  output logic                last
);

  localparam int IDX_W = $clog2(TABLE_SLOTS);

  ctrl_t            ctrl;
  stat_t            stat;
  logic [IDX_W-1:0] rd_addr;
  logic [IDX_W-1:0] ev_idx;

  ert_ctrl #(
    .TABLE_SLOTS(TABLE_SLOTS)
  ) u_ctrl (
    .clk    (clk),
    .rst    (rst),
    .start  (start),
    .cmd    (cmd),
    .busy   (busy),
    .stat   (stat),
    .ctrl   (ctrl),
    .rd_addr(rd_addr),
    .ev_idx (ev_idx)
  );

  ert_datapath #(
    .TABLE_SLOTS(TABLE_SLOTS)
  ) u_datapath (
    .clk           (clk),
    .rst           (rst),
    .ctrl          (ctrl),
    .rd_addr       (rd_addr),
    .ev_idx        (ev_idx),
    .stat          (stat),
    .event_key     (event_key),
    .event_kind    (event_kind),
    .retry_limit   (retry_limit),
    .retry_interval(retry_interval),
    .now_ms        (now_ms),
    .strobe        (strobe),
    .result_kind   (result_kind),
    .slot          (slot),
    .send_key      (send_key),
    .send_kind     (send_kind),
    .last          (last)
  );

endmodule

// ===== sv/ert_checker.sv =====
// Port-level checker for the event retry table, bound to the top level.
// Depends on ert_pkg.
module ert_port_checks
  import ert_pkg::*;
(
  input logic              clk,
  input logic              rst,
  input logic              start,
  input logic              busy,
  input logic [1:0]        cmd,
  input logic              strobe,
  input logic [RES_W-1:0]  result_kind,
  input logic [SLOT_W-1:0] slot,
  input logic [KEY_W-1:0]  send_key,
  input logic              last
);

  a_last_marks_end: assert property (@(posedge clk) disable iff (rst)
    strobe |-> (last == (result_kind != RK_SEND)))
    else $error("last does not match result kind");

  a_no_slot_fields: assert property (@(posedge clk) disable iff (rst)
    strobe && (result_kind == RK_FULL || result_kind == RK_NO_MATCH ||
               result_kind == RK_TICK_DONE) |-> (slot == '0) && (send_key == '0))
    else $error("slot or key set on a result without a slot");

  a_cmd_goes_busy: assert property (@(posedge clk) disable iff (rst)
    start && !busy && (cmd == CMD_ADD || cmd == CMD_ACK || cmd == CMD_TICK) |=> busy)
    else $error("accepted command did not raise busy");

  a_gap_after_last: assert property (@(posedge clk) disable iff (rst)
    strobe && last |=> !strobe)
    else $error("result beat right after final beat");

  a_send_while_busy: assert property (@(posedge clk) disable iff (rst)
    strobe && !last |-> busy)
    else $error("intermediate beat while idle");

endmodule

bind event_retry_table ert_port_checks u_ert_checker (
  .clk        (clk),
  .rst        (rst),
  .start      (start),
  .busy       (busy),
  .cmd        (cmd),
  .strobe     (strobe),
  .result_kind(result_kind),
  .slot       (slot),
  .send_key   (send_key),
  .last       (last)
);

// ===== sim/ert_checker.sv =====
// Scoreboard for the event retry table: tracks its own copy of the slot table,
// predicts the results of each accepted command and compares every result beat.
// Depends on ert_pkg.
module ert_checker
  import ert_pkg::*;
#(
  parameter int TABLE_SLOTS = TABLE_SLOTS_DEF
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  input  logic               busy,
  input  logic [1:0]         cmd,
  input  logic [KEY_W-1:0]   event_key,
  input  logic [KIND_W-1:0]  event_kind,
  input  logic [COUNT_W-1:0] retry_limit,
  input  logic [TIME_W-1:0]  retry_interval,
  input  logic [TIME_W-1:0]  now_ms,
  input  logic               strobe,
  input  logic [RES_W-1:0]   result_kind,
  input  logic [SLOT_W-1:0]  slot,
  input  logic [KEY_W-1:0]   send_key,
  input  logic               send_kind,
  input  logic               last,
  output int                 errors,
  output int                 pending,
  output int                 checked,
  output int                 sends
);

  typedef struct packed {
    logic [RES_W-1:0]  kind;
    logic [SLOT_W-1:0] slot;
    logic [KEY_W-1:0]  key;
    logic              skind;
    logic              last;
  } result_t;

  logic               tbl_valid  [TABLE_SLOTS];
  phase_t             tbl_phase  [TABLE_SLOTS];
  logic [KEY_W-1:0]   tbl_key    [TABLE_SLOTS];
  logic [KIND_W-1:0]  tbl_kind   [TABLE_SLOTS];
  logic [COUNT_W-1:0] tbl_target [TABLE_SLOTS];
  logic [COUNT_W-1:0] tbl_sent   [TABLE_SLOTS];
  logic [TIME_W-1:0]  tbl_wait   [TABLE_SLOTS];
  logic [TIME_W-1:0]  tbl_stamp  [TABLE_SLOTS];

  result_t due_results[$];
  result_t got, want;

  function automatic void free_slot(input int s);
    tbl_valid[s]  = 1'b0;
    tbl_phase[s]  = PH_READY;
    tbl_key[s]    = '0;
    tbl_kind[s]   = '0;
    tbl_target[s] = '0;
    tbl_sent[s]   = '0;
    tbl_wait[s]   = '0;
    tbl_stamp[s]  = '0;
  endfunction

  function automatic void queue_result(input res_kind_t k, input int s,
                                       input logic [KEY_W-1:0] key,
                                       input logic skind, input logic fin);
    result_t r;
    r.kind  = k;
    r.slot  = SLOT_W'(s);
    r.key   = key;
    r.skind = skind;
    r.last  = fin;
    due_results.push_back(r);
  endfunction

  function automatic void apply_command(input logic [1:0] c,
                                        input logic [KEY_W-1:0] key,
                                        input logic [KIND_W-1:0] kind,
                                        input logic [COUNT_W-1:0] limit,
                                        input logic [TIME_W-1:0] interval,
                                        input logic [TIME_W-1:0] now);
    bit hit;
    logic [TIME_W-1:0] elapsed;
    hit = 1'b0;
    case (c)
      CMD_ADD: begin
        for (int s = 0; s < TABLE_SLOTS && !hit; s++) begin
          if (!tbl_valid[s]) begin
            tbl_valid[s]  = 1'b1;
            tbl_phase[s]  = PH_READY;
            tbl_key[s]    = key;
            tbl_kind[s]   = kind;
            tbl_target[s] = limit;
            tbl_sent[s]   = '0;
            tbl_wait[s]   = interval;
            tbl_stamp[s]  = now;
            queue_result(RK_ADDED, s, '0, 1'b0, 1'b1);
            hit = 1'b1;
          end
        end
        if (!hit) queue_result(RK_FULL, 0, '0, 1'b0, 1'b1);
      end
      CMD_ACK: begin
        for (int s = 0; s < TABLE_SLOTS && !hit; s++) begin
          if (tbl_valid[s] && tbl_key[s] == key) begin
            free_slot(s);
            queue_result(RK_REMOVED, s, '0, 1'b0, 1'b1);
            hit = 1'b1;
          end
        end
        if (!hit) queue_result(RK_NO_MATCH, 0, '0, 1'b0, 1'b1);
      end
      CMD_TICK: begin
        for (int s = 0; s < TABLE_SLOTS; s++) begin
          if (tbl_valid[s]) begin
            case (tbl_phase[s])
              PH_READY: begin
                if (tbl_kind[s] == KIND_CHARGE || tbl_kind[s] == KIND_NETWORK)
                  queue_result(RK_SEND, s, tbl_key[s], tbl_kind[s][0], 1'b0);
                if (tbl_sent[s] != '1) tbl_sent[s] = tbl_sent[s] + 1'b1;
                if (tbl_sent[s] < tbl_target[s]) begin
                  tbl_phase[s] = PH_WAIT;
                  tbl_stamp[s] = now;
                end else begin
                  tbl_phase[s] = PH_DROP;
                end
              end
              PH_WAIT: begin
                elapsed = now - tbl_stamp[s];
                if (elapsed >= tbl_wait[s]) tbl_phase[s] = PH_READY;
              end
              PH_DROP: free_slot(s);
              default: ;
            endcase
          end
        end
        queue_result(RK_TICK_DONE, 0, '0, 1'b0, 1'b1);
      end
      default: ;
    endcase
  endfunction

  always @(posedge clk) begin
    if (rst) begin
      for (int s = 0; s < TABLE_SLOTS; s++) free_slot(s);
      due_results.delete();
      errors  = 0;
      checked = 0;
      sends   = 0;
    end else begin
      if (strobe) begin
        got = '{result_kind, slot, send_key, send_kind, last};
        checked++;
        if (result_kind == RK_SEND) sends++;
        if (due_results.size() == 0) begin
          errors++;
          $display("%0t: unexpected result: kind %0d slot %0d key %h skind %0d last %0d",
                   $time, got.kind, got.slot, got.key, got.skind, got.last);
        end else begin
          want = due_results.pop_front();
          if (got !== want) begin
            errors++;
            $display("%0t: mismatch: expected kind %0d slot %0d key %h skind %0d last %0d",
                     $time, want.kind, want.slot, want.key, want.skind, want.last);
            $display("%0t:           actual   kind %0d slot %0d key %h skind %0d last %0d",
                     $time, got.kind, got.slot, got.key, got.skind, got.last);
          end
        end
      end
      if (start && !busy)
        apply_command(cmd, event_key, event_kind, retry_limit, retry_interval, now_ms);
    end
    pending = due_results.size();
  end

endmodule

// ===== sim/testbench.sv =====
// Top of the event retry table bench: clock, reset, command stimulus and verdict.
// Depends on ert_pkg, event_retry_table and ert_checker.
module testbench;
  import ert_pkg::*;

  localparam int SLOTS       = TABLE_SLOTS_DEF;
  localparam int ITEM_TARGET = 480;
  localparam int CYCLE_LIMIT = 300000;
  localparam int KEY_POOL    = 20;

  localparam logic [1:0]        CMD_UNUSED = 2'd3;
  localparam logic [KIND_W-1:0] KIND_OTHER = 2'd2;
  localparam logic [KIND_W-1:0] KIND_SPARE = 2'd3;

  typedef enum int { MIX_FILL, MIX_CHURN, MIX_DRAIN } mix_t;

  logic                clk = 1'b0;
  logic                rst = 1'b1;
  logic                start = 1'b0;
  logic                busy;
  logic [1:0]          cmd = CMD_TICK;
  logic [KEY_W-1:0]    event_key = '0;
  logic [KIND_W-1:0]   event_kind = '0;
  logic [COUNT_W-1:0]  retry_limit = '0;
  logic [TIME_W-1:0]   retry_interval = '0;
  logic [TIME_W-1:0]   now_ms = '0;
  logic                strobe;
  logic [RES_W-1:0]    result_kind;
  logic [SLOT_W-1:0]   slot;
  logic [KEY_W-1:0]    send_key;
  logic                send_kind;
  logic                last;

  int fail_count, pending, checked, sends;
  int cycle_count = 0;
  int items = 0;
  bit steady = 1'b0;
  logic [TIME_W-1:0] clock_ms;
  logic [KEY_W-1:0]  key_pool [KEY_POOL];

  event_retry_table #(.TABLE_SLOTS(SLOTS)) i_dut (.*);

  ert_checker #(.TABLE_SLOTS(SLOTS)) i_check (
    .clk, .rst, .start, .busy, .cmd, .event_key, .event_kind, .retry_limit,
    .retry_interval, .now_ms, .strobe, .result_kind, .slot, .send_key,
    .send_kind, .last,
    .errors(fail_count), .pending(pending), .checked(checked), .sends(sends)
  );

  always #5 clk = ~clk;

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("testbench: timeout after %0d cycles", cycle_count);
      $display("testbench: FAIL");
      $finish;
    end
  end

  function automatic logic [KEY_W-1:0] any_key();
    return {$urandom, $urandom};
  endfunction

  function automatic logic [KEY_W-1:0] pool_key();
    if ($urandom_range(0, 99) < 88) return key_pool[$urandom_range(0, KEY_POOL - 1)];
    return any_key();
  endfunction

  function automatic logic [KIND_W-1:0] pick_kind();
    int r = $urandom_range(0, 99);
    if (r < 42) return KIND_CHARGE;
    if (r < 84) return KIND_NETWORK;
    if (r < 94) return KIND_OTHER;
    return KIND_SPARE;
  endfunction

  function automatic logic [COUNT_W-1:0] pick_limit();
    int r = $urandom_range(0, 99);
    if (r < 70) return COUNT_W'($urandom_range(0, 4));
    if (r < 90) return COUNT_W'($urandom_range(5, 10));
    return COUNT_W'($urandom);
  endfunction

  function automatic logic [TIME_W-1:0] pick_interval();
    int r = $urandom_range(0, 99);
    if (r < 60) return TIME_W'($urandom_range(0, 8));
    if (r < 85) return TIME_W'($urandom_range(9, 40));
    if (r < 95) return TIME_W'($urandom);
    return '1;
  endfunction

  function automatic logic [TIME_W-1:0] pick_step();
    int r = $urandom_range(0, 99);
    if (r < 80) return TIME_W'($urandom_range(0, 6));
    if (r < 95) return TIME_W'($urandom_range(7, 40));
    return TIME_W'($urandom);
  endfunction

  task automatic idle_gap();
    int r = $urandom_range(0, 99);
    int n;
    if (steady || r < 55) n = 0;
    else if (r < 88) n = $urandom_range(1, 3);
    else if (r < 97) n = $urandom_range(4, 12);
    else n = $urandom_range(20, 45);
    if (n > 0) begin
      start = 1'b0;
      repeat (n) @(negedge clk);
    end
  endtask

  // Drive one beat at the falling edge and hold it until accepted.
  task automatic issue(input logic [1:0] c, input logic [KEY_W-1:0] key,
                       input logic [KIND_W-1:0] kind, input logic [COUNT_W-1:0] limit,
                       input logic [TIME_W-1:0] interval);
    cmd            = c;
    event_key      = key;
    event_kind     = kind;
    retry_limit    = limit;
    retry_interval = interval;
    now_ms         = clock_ms;
    start          = 1'b1;
    @(posedge clk);
    while (busy) @(posedge clk);
    @(negedge clk);
    if (c != CMD_UNUSED) items++;
    idle_gap();
  endtask

  task automatic tick(input logic [TIME_W-1:0] step);
    clock_ms = clock_ms + step;
    issue(CMD_TICK, any_key(), KIND_W'($urandom), COUNT_W'($urandom), TIME_W'($urandom));
  endtask

  task automatic random_item(input mix_t mix);
    int r = $urandom_range(0, 99);
    int add_pct, tick_pct;
    case (mix)
      MIX_FILL:  begin add_pct = 85; tick_pct = 7;  end
      MIX_CHURN: begin add_pct = 35; tick_pct = 32; end
      default:   begin add_pct = 6;  tick_pct = 66; end
    endcase
    if (r < 3)
      issue(CMD_UNUSED, any_key(), KIND_W'($urandom), COUNT_W'($urandom), TIME_W'($urandom));
    else if (r < 3 + add_pct)
      issue(CMD_ADD, pool_key(), pick_kind(), pick_limit(), pick_interval());
    else if (r < 3 + add_pct + tick_pct)
      tick(pick_step());
    else
      issue(CMD_ACK, pool_key(), KIND_W'($urandom), COUNT_W'($urandom), TIME_W'($urandom));
  endtask

  initial begin
    int phase_no, len;
    mix_t mix;
    key_pool[0] = '0;
    key_pool[1] = '1;
    for (int k = 2; k < KEY_POOL; k++) key_pool[k] = any_key();
    clock_ms = 32'hFFFF_FFF8;
    repeat (3) @(negedge clk);
    rst = 1'b0;

    // directed: empty table, extremes, kinds that never send, zero limit, time wrap
    issue(CMD_UNUSED, '1, KIND_SPARE, '1, '1);
    issue(CMD_ACK, '0, KIND_CHARGE, '0, '0);
    tick(0);
    issue(CMD_ADD, '0, KIND_CHARGE, 8'd0, 32'd0);
    issue(CMD_ADD, '1, KIND_NETWORK, 8'hFF, 32'hFFFF_FFFF);
    issue(CMD_ADD, key_pool[2], KIND_OTHER, 8'd2, 32'd3);
    issue(CMD_ADD, key_pool[3], KIND_SPARE, 8'd1, 32'd0);
    issue(CMD_ADD, '1, KIND_CHARGE, 8'd3, 32'd5);
    tick(0);
    tick(10);
    tick(1);
    issue(CMD_ACK, '1, KIND_SPARE, '1, '1);
    issue(CMD_ACK, '1, KIND_SPARE, '1, '1);
    issue(CMD_ACK, '1, KIND_SPARE, '1, '1);
    tick(0);
    tick(0);
    issue(CMD_UNUSED, '0, KIND_CHARGE, '0, '0);

    phase_no = 0;
    while (items < ITEM_TARGET) begin
      mix = (phase_no == 0) ? MIX_FILL : mix_t'($urandom_range(0, 2));
      steady = ($urandom_range(0, 3) == 0);
      len = $urandom_range(10, 30);
      for (int i = 0; i < len && items < ITEM_TARGET; i++) random_item(mix);
      if (phase_no % 4 == 0) begin
        start = 1'b0;
        while (pending != 0) @(negedge clk);
      end
      phase_no++;
    end

    start = 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (SLOTS + 4) @(negedge clk);
    $display("testbench: %0d commands, %0d result beats checked, %0d send requests",
             items, checked, sends);
    $display("testbench: add, ack and tick over full and empty tables, shared keys, wrapping time");
    if (fail_count == 0)
      $display("testbench: PASS");
    else
      $display("testbench: FAIL");
    $finish;
  end

endmodule

// ===== filelist.f =====
sv/ert_pkg.sv
sv/ert_ram.sv
sv/ert_datapath.sv
sv/ert_ctrl.sv
sv/event_retry_table.sv
sv/ert_checker.sv
sim/ert_checker.sv
sim/testbench.sv
